// ===== sv/tld_pkg.sv =====
// Shared definitions for the terminal line discipline: sizes, character
// codes, result kinds and the command/status bundles between controller
// and datapath. No dependencies.
`default_nettype none

package tld_pkg;

    // Edit line geometry.
    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ECHO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Result kinds.
    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_INTR    = 2'd2;
    localparam logic [1:0] KIND_EOF     = 2'd3;

    // Trailing result sequence for a byte, sent after any line delivery.
    typedef enum logic [2:0] {
        TAIL_CRLF  = 3'd0,
        TAIL_INTR  = 3'd1,
        TAIL_EOF   = 3'd2,
        TAIL_BYTE  = 3'd3,
        TAIL_CARET = 3'd4,
        TAIL_ERASE = 3'd5,
        TAIL_QUEST = 3'd6
    } tail_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;
        logic decode;
        logic line_start;
        logic line_next;
        logic line_done;
        logic show_line;
        logic tail_next;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_flush;
        logic plan_tail;
        logic line_last;
        logic tail_last;
        logic has_tail;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/tld_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/tld_ctrl.sv =====
// Controller of the terminal line discipline: sequences decode, line
// delivery and trailing results, and owns both handshakes.
// Depends on tld_pkg.
`default_nettype none

module tld_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire tld_pkg::sts_t sts,
    output tld_pkg::cmd_t      cmd
);

    import tld_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_LINE   = 5'b01000,
        S_TAIL   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state, commands and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.plan_flush)
                begin
                    state_next = S_READ;
                end
                else if (sts.plan_tail)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.line_start = 1'b1;
                state_next     = S_LINE;
            end
            S_LINE:
            begin
                out_valid     = 1'b1;
                cmd.show_line = 1'b1;
                if (out_ready)
                begin
                    if (sts.line_last)
                    begin
                        cmd.line_done = 1'b1;
                        state_next    = sts.has_tail ? S_TAIL : S_IDLE;
                    end
                    else
                    begin
                        cmd.line_next = 1'b1;
                    end
                end
            end
            S_TAIL:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.tail_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.tail_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tld_dp.sv =====
// Datapath of the terminal line discipline: configuration registers,
// byte classification, edit line store and result formatting.
// Depends on tld_pkg and tld_ram.
`default_nettype none

module tld_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tld_pkg::cmd_t                     cmd,
    output tld_pkg::sts_t                          sts,
    input  wire logic [7:0]                        rx_byte,
    input  wire logic                              cfg_we,
    input  wire logic [tld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tld_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [1:0]                             kind,
    output logic [7:0]                             data,
    output logic [15:0]                            group,
    output logic                                   last
);

    import tld_pkg::*;

    // Configuration registers.
    logic        echo_reg;
    logic        raw_reg;
    logic [15:0] group_reg;

    // Working registers.
    logic [7:0]        byte_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    tail_t             tail_code_reg;
    logic [1:0]        tail_cnt_reg;
    logic [1:0]        tail_idx_reg;
    logic [1:0]        tail_idx_next;

    // Decode plan for the latched byte.
    logic       plan_store;
    logic       plan_dec;
    logic       plan_flush;
    tail_t      plan_code;
    logic [1:0] plan_cnt;
    logic [7:0] store_byte;

    // Line store port signals.
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Trailing result fields.
    logic [1:0]  tail_kind;
    logic [7:0]  tail_data;
    logic [15:0] tail_group;

    logic is_eol;
    logic is_print;
    logic has_room;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg  <= 1'b1;
            raw_reg   <= 1'b0;
            group_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ECHO:  echo_reg  <= cfg_data[0];
                REG_RAW:   raw_reg   <= cfg_data[0];
                REG_GROUP: group_reg <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Received byte, held for the whole item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Classify the byte and work out stores, delivery and trailing results.
    always_comb
    begin
        is_eol     = (byte_reg == CH_CR) || (byte_reg == CH_LF);
        is_print   = (byte_reg >= CH_SPACE) && (byte_reg <= CH_TILDE);
        has_room   = fill_reg < FILL_W'(LINE_DEPTH - 1);
        plan_store = 1'b0;
        plan_dec   = 1'b0;
        plan_flush = 1'b0;
        plan_code  = TAIL_BYTE;
        plan_cnt   = 2'd0;
        store_byte = byte_reg;
        if (is_eol)
        begin
            plan_store = 1'b1;
            plan_flush = 1'b1;
            store_byte = CH_LF;
            plan_code  = TAIL_CRLF;
            plan_cnt   = echo_reg ? 2'd2 : 2'd0;
        end
        else if ((byte_reg == CH_CAN) || (byte_reg == CH_ETX))
        begin
            plan_code = TAIL_INTR;
            plan_cnt  = 2'd1;
        end
        else if (byte_reg == CH_EOT)
        begin
            plan_code = TAIL_EOF;
            plan_cnt  = 2'd1;
        end
        else if (raw_reg)
        begin
            plan_store = 1'b1;
            plan_flush = 1'b1;
            plan_cnt   = echo_reg ? 2'd1 : 2'd0;
        end
        else if (is_print)
        begin
            // A full line drops the byte without echo.
            if (has_room)
            begin
                plan_store = 1'b1;
                plan_cnt   = echo_reg ? 2'd1 : 2'd0;
            end
        end
        else if (byte_reg < CH_SPACE)
        begin
            plan_code = TAIL_CARET;
            plan_cnt  = echo_reg ? 2'd2 : 2'd0;
        end
        else if (byte_reg == CH_DEL)
        begin
            if (fill_reg != '0)
            begin
                plan_dec  = 1'b1;
                plan_code = TAIL_ERASE;
                plan_cnt  = echo_reg ? 2'd3 : 2'd0;
            end
        end
        else
        begin
            // High bytes always echo a question mark.
            plan_code = TAIL_QUEST;
            plan_cnt  = 2'd1;
        end
    end

    // Fill count, delivery index and trailing result index.
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.decode && plan_store)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (cmd.decode && plan_dec)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
        else if (cmd.line_done)
        begin
            fill_next = '0;
        end

        idx_next = idx_reg;
        if (cmd.line_start)
        begin
            idx_next = '0;
        end
        else if (cmd.line_next)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end

        tail_idx_next = tail_idx_reg;
        if (cmd.decode)
        begin
            tail_idx_next = 2'd0;
        end
        else if (cmd.tail_next)
        begin
            tail_idx_next = tail_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            tail_idx_reg  <= 2'd0;
            tail_cnt_reg  <= 2'd0;
            tail_code_reg <= TAIL_BYTE;
        end
        else
        begin
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            tail_idx_reg <= tail_idx_next;
            if (cmd.decode)
            begin
                tail_cnt_reg  <= plan_cnt;
                tail_code_reg <= plan_code;
            end
        end
    end

    // Edit line store: write at the fill point, read ahead during delivery.
    assign ram_we    = cmd.decode && plan_store;
    assign ram_re    = cmd.line_start || cmd.line_next;
    assign ram_raddr = idx_next;

    tld_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (store_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Trailing result for the current position in the sequence.
    always_comb
    begin
        tail_kind  = KIND_ECHO;
        tail_data  = 8'd0;
        tail_group = 16'd0;
        case (tail_code_reg)
            TAIL_CRLF:  tail_data = (tail_idx_reg == 2'd0) ? CH_CR : CH_LF;
            TAIL_INTR:
            begin
                tail_kind  = KIND_INTR;
                tail_group = group_reg;
            end
            TAIL_EOF:   tail_kind = KIND_EOF;
            TAIL_BYTE:  tail_data = byte_reg;
            TAIL_CARET: tail_data = (tail_idx_reg == 2'd0) ? CH_CARET : CH_AT + byte_reg;
            TAIL_ERASE: tail_data = (tail_idx_reg == 2'd1) ? CH_SPACE : CH_BS;
            TAIL_QUEST: tail_data = CH_QUEST;
            default:    tail_data = 8'd0;
        endcase
    end

    // Status for the controller.
    always_comb
    begin
        sts.plan_flush = plan_flush;
        sts.plan_tail  = plan_cnt != 2'd0;
        sts.line_last  = FILL_W'(idx_reg) == (fill_reg - FILL_W'(1));
        sts.tail_last  = tail_idx_reg == (tail_cnt_reg - 2'd1);
        sts.has_tail   = tail_cnt_reg != 2'd0;
    end

    // Output beat fields.
    always_comb
    begin
        if (cmd.show_line)
        begin
            kind  = KIND_DELIVER;
            data  = ram_rdata;
            group = 16'd0;
            last  = sts.line_last && !sts.has_tail;
        end
        else
        begin
            kind  = tail_kind;
            data  = tail_data;
            group = tail_group;
            last  = sts.tail_last;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tty_line_discipline_top.sv =====
// Terminal line discipline: one received byte per input beat, zero to
// LINE_DEPTH+2 result beats per byte. The first result follows the decode
// state, or the decode and RAM read states when a line is delivered. Line
// bytes stream at one per cycle from the line RAM while out_ready is high;
// a byte holds the block through decode, its results and any RAM read.
// Reset clears the fill count and restores echo on, line mode, group 0.
// Depends on tld_pkg, tld_ctrl and tld_dp.
`default_nettype none

module tty_line_discipline_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             kind,
    output logic [7:0]                             data,
    output logic [15:0]                            group,
    output logic                                   last,
    input  wire logic                              cfg_we,
    input  wire logic [tld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tld_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tld_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing and handshakes.
    tld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Line store, registers and result formatting.
    tld_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .data      (data),
        .group     (group),
        .last      (last)
    );

endmodule

`default_nettype wire
